[rtl/pcapdf_pkg.sv]
// Shared types, constants and helpers for the capture file deframer.
package pcapdf_pkg;

  // Magic words, as read big-endian from the first four file bytes
  localparam logic [31:0] MAGIC_USEC_BE = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_USEC_LE = 32'hd4c3b2a1;
  localparam logic [31:0] MAGIC_NSEC_BE = 32'ha1b23c4d;
  localparam logic [31:0] MAGIC_NSEC_LE = 32'h4d3cb2a1;

  localparam int GLOBAL_LEN = 24;
  localparam int RECORD_LEN = 16;
  localparam int LINK_W     = 28;

  // Byte positions inside the headers
  localparam logic [4:0] IDX_MAGIC_LAST  = 5'd3;
  localparam logic [4:0] IDX_GLOBAL_LAST = 5'(GLOBAL_LEN - 1);
  localparam logic [4:0] IDX_DEAD        = 5'(GLOBAL_LEN);
  localparam logic [4:0] IDX_SECONDS     = 5'd3;
  localparam logic [4:0] IDX_FRACTION    = 5'd7;
  localparam logic [4:0] IDX_CAPLEN      = 5'd11;
  localparam logic [4:0] IDX_RECORD_LAST = 5'(RECORD_LEN - 1);

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_GLOBAL    = 2'd0,
    PH_RECORD    = 2'd1,
    PH_PAYLOAD   = 2'd2,
    PH_BAD_MAGIC = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_MAGIC = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          payload_byte;
    logic                frame_end;
    logic [31:0]         seconds;
    logic [31:0]         nanoseconds;
    logic [31:0]         captured_len;
    logic [31:0]         original_len;
    logic [LINK_W-1:0]   link_type;
    logic [1:0]          error_code;
    logic                run_last;
  } result_t;

  // x * 1000 mod 2^32 as 1024x - 16x - 8x
  function automatic logic [31:0] usec_to_nsec(input logic [31:0] us);
    usec_to_nsec = (us << 10) - (us << 4) - (us << 3);
  endfunction

endpackage

[rtl/pcap_record_deframer_core.sv]
// Classic capture file deframer: byte stream in, frame headers and payload words out.
// Each result word enters a four-word result queue when its file byte is accepted.
// Throughput: one file byte per cycle while two queue slots are free; each byte
// yields up to two result words, drained one per cycle while out_ready is high.
// Reset: rst_n (synchronous, active low) returns the parser to the global header
// and empties the queue; an end-of-file byte also rearms the parser.
module pcap_record_deframer_core
  import pcapdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // file byte channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_file_byte,
  input  logic              in_end_of_file,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_payload_byte,
  output logic              out_frame_end,
  output logic [31:0]       out_seconds,
  output logic [31:0]       out_nanoseconds,
  output logic [31:0]       out_captured_len,
  output logic [31:0]       out_original_len,
  output logic [LINK_W-1:0] out_link_type,
  output logic [1:0]        out_error_code,
  output logic              out_run_last
);

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_t            phase_r,   phase_nxt;
  logic [4:0]        idx_r,     idx_nxt;     // byte position inside current header
  logic              le_r,      le_nxt;      // file is little endian
  logic              nano_r,    nano_nxt;    // fraction already in nanoseconds
  logic [31:0]       word_r,    word_nxt;    // 32-bit field assembly
  logic [LINK_W-1:0] link_r,    link_nxt;
  logic [31:0]       secs_r,    secs_nxt;
  logic [31:0]       frac_r,    frac_nxt;    // stored already scaled to ns
  logic [31:0]       caplen_r,  caplen_nxt;
  logic [31:0]       left_r,    left_nxt;    // payload bytes still expected

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Shared decode of the current byte
  // ---------------------------------------------------------------------------
  logic        in_global;     // global header or bad-magic phase
  logic        dead;          // past a bad magic header, bytes ignored
  logic        shift_in_low;  // big-endian style: new byte enters at the bottom
  logic [31:0] word_new;
  logic        magic_known;
  logic        bad_now;       // bad magic after this byte
  logic [31:0] left_dec;

  assign in_global = (phase_r == PH_GLOBAL) || (phase_r == PH_BAD_MAGIC);
  assign dead      = (phase_r == PH_BAD_MAGIC) && (idx_r >= IDX_DEAD);

  // magic bytes are always big-endian; after that, the file's byte order rules
  assign shift_in_low = (in_global && idx_r < 5'd4) || !le_r;
  assign word_new     = shift_in_low ? {word_r[23:0], in_file_byte}
                                     : {in_file_byte, word_r[31:8]};

  assign magic_known = (word_new == MAGIC_USEC_BE) || (word_new == MAGIC_USEC_LE) ||
                       (word_new == MAGIC_NSEC_BE) || (word_new == MAGIC_NSEC_LE);
  assign bad_now     = (phase_r == PH_BAD_MAGIC) ||
                       ((idx_r == IDX_MAGIC_LAST) && !magic_known);

  // payload counter saturates at zero
  assign left_dec = (left_r != 32'd0) ? left_r - 32'd1 : 32'd0;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    le_nxt     = le_r;
    nano_nxt   = nano_r;
    word_nxt   = word_r;
    link_nxt   = link_r;
    secs_nxt   = secs_r;
    frac_nxt   = frac_r;
    caplen_nxt = caplen_r;
    left_nxt   = left_r;

    case (phase_r)
      PH_GLOBAL, PH_BAD_MAGIC: begin
        if (!dead) begin
          word_nxt = word_new;
          if (idx_r == IDX_MAGIC_LAST) begin
            case (word_new)
              MAGIC_USEC_BE: begin le_nxt = 1'b0; nano_nxt = 1'b0; end
              MAGIC_USEC_LE: begin le_nxt = 1'b1; nano_nxt = 1'b0; end
              MAGIC_NSEC_BE: begin le_nxt = 1'b0; nano_nxt = 1'b1; end
              MAGIC_NSEC_LE: begin le_nxt = 1'b1; nano_nxt = 1'b1; end
              default:       phase_nxt = PH_BAD_MAGIC;
            endcase
          end
          if (idx_r == IDX_GLOBAL_LAST) begin
            if (bad_now) begin
              idx_nxt = IDX_DEAD;
            end else begin
              link_nxt  = word_new[LINK_W-1:0];
              phase_nxt = PH_RECORD;
              idx_nxt   = '0;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      PH_RECORD: begin
        word_nxt = word_new;
        if (idx_r == IDX_SECONDS)  secs_nxt   = word_new;
        if (idx_r == IDX_FRACTION) frac_nxt   = nano_r ? word_new : usec_to_nsec(word_new);
        if (idx_r == IDX_CAPLEN)   caplen_nxt = word_new;
        if (idx_r == IDX_RECORD_LAST) begin
          left_nxt = caplen_r;
          idx_nxt  = '0;
          if (caplen_r != 32'd0) phase_nxt = PH_PAYLOAD;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          phase_nxt = PH_RECORD;
          idx_nxt   = '0;
        end
      end
      default: phase_nxt = PH_GLOBAL;
    endcase

    // end of file rearms everything
    if (in_end_of_file) begin
      phase_nxt  = PH_GLOBAL;
      idx_nxt    = '0;
      le_nxt     = 1'b0;
      nano_nxt   = 1'b0;
      word_nxt   = '0;
      link_nxt   = '0;
      secs_nxt   = '0;
      frac_nxt   = '0;
      caplen_nxt = '0;
      left_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GLOBAL;
      idx_r    <= '0;
      le_r     <= 1'b0;
      nano_r   <= 1'b0;
      word_r   <= '0;
      link_r   <= '0;
      secs_r   <= '0;
      frac_r   <= '0;
      caplen_r <= '0;
      left_r   <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      le_r     <= le_nxt;
      nano_r   <= nano_nxt;
      word_r   <= word_nxt;
      link_r   <= link_nxt;
      secs_r   <= secs_nxt;
      frac_r   <= frac_nxt;
      caplen_r <= caplen_nxt;
      left_r   <= left_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result words for the current byte (zero, one or two)
  // ---------------------------------------------------------------------------
  result_t    res0, res1;
  logic [1:0] n_res;

  always_comb begin
    res0  = '0;
    res1  = '0;
    n_res = 2'd0;

    case (phase_r)
      PH_GLOBAL, PH_BAD_MAGIC: begin
        if (!dead) begin
          if (idx_r == IDX_GLOBAL_LAST) begin
            if (bad_now) begin
              res0.kind       = KIND_ERROR;
              res0.error_code = ERR_MAGIC;
              n_res           = 2'd1;
            end
          end else if (in_end_of_file) begin
            // file ended inside the global header
            res0.kind       = KIND_ERROR;
            res0.error_code = ERR_SHORT;
            n_res           = 2'd1;
          end
        end
      end
      PH_RECORD: begin
        if (idx_r == IDX_RECORD_LAST) begin
          res0.kind         = KIND_HEADER;
          res0.frame_end    = (caplen_r == 32'd0);
          res0.seconds      = secs_r;
          res0.nanoseconds  = frac_r;
          res0.captured_len = caplen_r;
          res0.original_len = word_new;
          res0.link_type    = link_r;
          n_res             = 2'd1;
          if ((caplen_r != 32'd0) && in_end_of_file) begin
            res1.kind       = KIND_ERROR;
            res1.error_code = ERR_TRUNC;
            n_res           = 2'd2;
          end
        end
      end
      PH_PAYLOAD: begin
        res0.kind         = KIND_DATA;
        res0.payload_byte = in_file_byte;
        res0.frame_end    = (left_dec == 32'd0);
        n_res             = 2'd1;
        if ((left_dec != 32'd0) && in_end_of_file) begin
          res1.kind       = KIND_ERROR;
          res1.error_code = ERR_TRUNC;
          n_res           = 2'd2;
        end
      end
      default: n_res = 2'd0;
    endcase

    // mark the last word caused by this byte
    if (n_res == 2'd2) res1.run_last = 1'b1;
    else               res0.run_last = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result queue: takes up to two words per byte, sends one per cycle while out_ready is high.
  // Input is held off unless two free slots are guaranteed.
  // ---------------------------------------------------------------------------
  result_t               q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   cnt_r,    cnt_nxt;
  logic [1:0]            n_wr;
  logic                  out_acc;

  assign in_ready  = (cnt_r <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign n_wr      = in_acc ? n_res : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(n_wr);
    rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(out_acc);
    cnt_nxt    = cnt_r + QUEUE_CW'(n_wr) - QUEUE_CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) q_mem[wr_ptr_r] <= res0;
    if (n_wr == 2'd2) q_mem[wr_ptr_r + QUEUE_AW'(1)] <= res1;
  end

  result_t head;
  assign head = q_mem[rd_ptr_r];

  assign out_kind         = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_frame_end    = head.frame_end;
  assign out_seconds      = head.seconds;
  assign out_nanoseconds  = head.nanoseconds;
  assign out_captured_len = head.captured_len;
  assign out_original_len = head.original_len;
  assign out_link_type    = head.link_type;
  assign out_error_code   = head.error_code;
  assign out_run_last     = head.run_last;

endmodule

[test/pcap_record_deframer_core_test.sv]
// Self-checking testbench for the capture file deframer core.
module pcap_record_deframer_core_test;
  import pcapdf_pkg::*;

  // One file byte as the sender offers it; typed_err, when set, replaces the
  // predicted last result of this byte with a hand-written error report.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] typed_err;
  } capture_byte_t;

  // One directed capture file. stop_at cuts the file after that many bytes,
  // 0 keeps it whole. Records reuse caplen and stamp (original length ~stamp).
  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] link_word;
    logic [3:0]  records;
    logic [31:0] caplen;
    logic [31:0] stamp;
    logic [15:0] stop_at;
    logic [1:0]  typed_err;
  } file_plan_t;

  localparam int ITEMS_WANTED = 850;
  localparam int HOLD_CYCLES  = 200;

  localparam file_plan_t DIRECTED [12] = '{
    // magic          link           rec   caplen         stamp         stop    typed
    '{32'hffffffff,   32'h00000000,  4'd0, 32'd0,         32'h00000000, 16'd1,  ERR_SHORT},
    '{32'h00000000,   32'hffffffff,  4'd0, 32'd0,         32'h00000000, 16'd23, ERR_SHORT},
    '{MAGIC_USEC_BE,  32'h00000000,  4'd0, 32'd0,         32'h00000000, 16'd5,  ERR_SHORT},
    '{32'ha1b2c3d5,   32'h00000001,  4'd0, 32'd0,         32'h00000000, 16'd24, ERR_MAGIC},
    '{MAGIC_USEC_LE,  32'hffffffff,  4'd2, 32'd0,         32'hffffffff, 16'd0,  ERR_NONE},
    '{MAGIC_NSEC_BE,  32'h00000000,  4'd2, 32'd1,         32'h00000000, 16'd0,  ERR_NONE},
    '{MAGIC_NSEC_LE,  32'h00000001,  4'd1, 32'hffffffff,  32'h80000000, 16'd45, ERR_TRUNC},
    '{MAGIC_USEC_BE,  32'h0fffffff,  4'd1, 32'd4,         32'h00418938, 16'd40, ERR_TRUNC},
    '{MAGIC_USEC_LE,  32'h10000001,  4'd2, 32'd2,         32'h12345678, 16'd49, ERR_NONE},
    '{MAGIC_NSEC_BE,  32'h00000071,  4'd0, 32'd0,         32'h00000000, 16'd0,  ERR_NONE},
    '{32'h12345678,   32'h00000001,  4'd3, 32'd5,         32'h00000005, 16'd0,  ERR_NONE},
    '{MAGIC_USEC_BE,  32'h00000001,  4'd3, 32'd3,         32'h7fffffff, 16'd0,  ERR_NONE}
  };

  logic [31:0] good_magics [4] = '{MAGIC_USEC_BE, MAGIC_USEC_LE, MAGIC_NSEC_BE, MAGIC_NSEC_LE};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_file_byte = 8'h00;
  logic              in_end_of_file = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [7:0]        out_payload_byte;
  logic              out_frame_end;
  logic [31:0]       out_seconds;
  logic [31:0]       out_nanoseconds;
  logic [31:0]       out_captured_len;
  logic [31:0]       out_original_len;
  logic [LINK_W-1:0] out_link_type;
  logic [1:0]        out_error_code;
  logic              out_run_last;

  pcap_record_deframer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_file_byte     (in_file_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_end    (out_frame_end),
    .out_seconds      (out_seconds),
    .out_nanoseconds  (out_nanoseconds),
    .out_captured_len (out_captured_len),
    .out_original_len (out_original_len),
    .out_link_type    (out_link_type),
    .out_error_code   (out_error_code),
    .out_run_last     (out_run_last)
  );

  always #4 clk = ~clk;

  capture_byte_t capture_bytes [$];
  logic [7:0]    file_image [$];
  result_t       parsed_words [$];
  int            accepted_count = 0;
  int            results_taken = 0;
  int            fails = 0;
  int            cycle_count = 0;
  int            cycle_limit = 0;

  // Parser shadow state
  phase_t            parse_phase;
  logic [4:0]        hdr_index;
  logic              is_le;
  logic              is_nano;
  logic [31:0]       shift_word;
  logic [LINK_W-1:0] link_kept;
  logic [31:0]       rec_sec;
  logic [31:0]       rec_frac;
  logic [31:0]       rec_caplen;
  logic [31:0]       bytes_left;

  task automatic clear_parser();
    parse_phase = PH_GLOBAL;
    hdr_index   = '0;
    is_le       = 1'b0;
    is_nano     = 1'b0;
    shift_word  = '0;
    link_kept   = '0;
    rec_sec     = '0;
    rec_frac    = '0;
    rec_caplen  = '0;
    bytes_left  = '0;
  endtask

  task automatic note_error(input logic [1:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    parsed_words.insert(parsed_words.size(), r);
  endtask

  // Advance the shadow parser by one file byte, queueing the words it yields.
  task automatic parse_file_byte(input logic [7:0] b, input logic eof);
    result_t r;
    int      n0;
    n0 = parsed_words.size();
    if (parse_phase == PH_GLOBAL || parse_phase == PH_BAD_MAGIC) begin
      if (!(parse_phase == PH_BAD_MAGIC && hdr_index >= IDX_DEAD)) begin
        // magic always big-endian; the rest follows the detected order
        if (hdr_index < 5'd4 || !is_le) shift_word = {shift_word[23:0], b};
        else shift_word = {b, shift_word[31:8]};
        if (hdr_index == IDX_MAGIC_LAST) begin
          case (shift_word)
            MAGIC_USEC_BE: begin is_le = 1'b0; is_nano = 1'b0; end
            MAGIC_USEC_LE: begin is_le = 1'b1; is_nano = 1'b0; end
            MAGIC_NSEC_BE: begin is_le = 1'b0; is_nano = 1'b1; end
            MAGIC_NSEC_LE: begin is_le = 1'b1; is_nano = 1'b1; end
            default: parse_phase = PH_BAD_MAGIC;
          endcase
        end
        if (hdr_index == IDX_GLOBAL_LAST) begin
          if (parse_phase == PH_BAD_MAGIC) begin
            note_error(ERR_MAGIC);
            hdr_index = IDX_DEAD;
          end else begin
            link_kept = shift_word[LINK_W-1:0];
            parse_phase = PH_RECORD;
            hdr_index = '0;
          end
        end else begin
          hdr_index = hdr_index + 5'd1;
          if (eof) note_error(ERR_SHORT);
        end
      end
    end else if (parse_phase == PH_RECORD) begin
      if (is_le) shift_word = {b, shift_word[31:8]};
      else shift_word = {shift_word[23:0], b};
      case (hdr_index)
        IDX_SECONDS:  rec_sec = shift_word;
        IDX_FRACTION: rec_frac = shift_word;
        IDX_CAPLEN:   rec_caplen = shift_word;
        default: ;
      endcase
      if (hdr_index == IDX_RECORD_LAST) begin
        r = '0;
        r.kind = KIND_HEADER;
        r.frame_end = (rec_caplen == 32'd0);
        r.seconds = rec_sec;
        r.nanoseconds = is_nano ? rec_frac : rec_frac * 32'd1000;
        r.captured_len = rec_caplen;
        r.original_len = shift_word;
        r.link_type = link_kept;
        parsed_words.insert(parsed_words.size(), r);
        bytes_left = rec_caplen;
        hdr_index = '0;
        if (bytes_left != 32'd0) begin
          parse_phase = PH_PAYLOAD;
          if (eof) note_error(ERR_TRUNC);
        end
      end else begin
        hdr_index = hdr_index + 5'd1;
      end
    end else begin
      r = '0;
      r.kind = KIND_DATA;
      r.payload_byte = b;
      if (bytes_left != 32'd0) bytes_left = bytes_left - 32'd1;
      if (bytes_left == 32'd0) begin
        r.frame_end = 1'b1;
        parse_phase = PH_RECORD;
        hdr_index = '0;
        parsed_words.insert(parsed_words.size(), r);
      end else begin
        parsed_words.insert(parsed_words.size(), r);
        if (eof) note_error(ERR_TRUNC);
      end
    end
    if (parsed_words.size() > n0) parsed_words[$].run_last = 1'b1;
    if (eof) clear_parser();
  endtask

  task automatic put_word(input logic [31:0] w, input logic le);
    for (int i = 0; i < 4; i++)
      file_image.insert(file_image.size(), le ? w[8*i +: 8] : w[8*(3-i) +: 8]);
  endtask

  // Build one capture file and queue its bytes; vary draws fresh record fields.
  // useful counts the bytes the parser actually works on.
  task automatic add_file(input file_plan_t plan, input logic vary, output int useful);
    logic          le;
    logic          known;
    logic [31:0]   cap;
    logic [31:0]   sec;
    logic [31:0]   frac;
    logic [31:0]   orig;
    int            n;
    int            pick;
    capture_byte_t cb;
    file_image.delete();
    known = (plan.magic == MAGIC_USEC_BE || plan.magic == MAGIC_USEC_LE ||
             plan.magic == MAGIC_NSEC_BE || plan.magic == MAGIC_NSEC_LE);
    le = (plan.magic == MAGIC_USEC_LE || plan.magic == MAGIC_NSEC_LE);
    put_word(plan.magic, 1'b0);
    for (int i = 0; i < 4; i++) put_word($urandom(), le);
    put_word(plan.link_word, le);
    for (int k = 0; k < plan.records; k++) begin
      if (vary) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) cap = 32'd0;
        else if (pick < 75) cap = $urandom_range(1, 8);
        else if (pick < 95) cap = $urandom_range(9, 40);
        else cap = $urandom() | 32'h100;  // runs past the end of the file
        sec  = $urandom();
        frac = $urandom();
        orig = $urandom();
      end else begin
        cap  = plan.caplen;
        sec  = plan.stamp;
        frac = plan.stamp;
        orig = ~plan.stamp;
      end
      put_word(sec, le);
      put_word(frac, le);
      put_word(cap, le);
      put_word(orig, le);
      n = (cap > 32'd64) ? 64 : int'(cap);
      repeat (n) file_image.insert(file_image.size(), 8'($urandom()));
    end
    if (plan.stop_at != 16'd0)
      while (file_image.size() > int'(plan.stop_at)) void'(file_image.pop_back());
    foreach (file_image[i]) begin
      cb.data      = file_image[i];
      cb.last      = (i == file_image.size() - 1);
      cb.typed_err = (i == file_image.size() - 1) ? plan.typed_err : ERR_NONE;
      capture_bytes.insert(capture_bytes.size(), cb);
    end
    useful = (known || file_image.size() < GLOBAL_LEN) ? file_image.size() : GLOBAL_LEN;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 5);
    return $urandom_range(12, 40);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Sender: one file byte per handshake, random gaps, valid held until taken.
  initial begin : sender
    int  pos;
    int  gap;
    bit  tx_steady;
    tx_steady = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    for (pos = 0; pos < capture_bytes.size(); pos++) begin
      if (pos % 40 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      if (!tx_steady && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid       <= 1'b1;
      in_file_byte   <= capture_bytes[pos].data;
      in_end_of_file <= capture_bytes[pos].last;
      do @(negedge clk); while (accepted_count <= pos);
    end
    in_valid <= 1'b0;
  end

  // Receiver: random stalls, plus long hold-offs that back the block up.
  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_done;
    int rx_cycles;
    bit rx_steady;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    rx_cycles  = 0;
    rx_steady  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if ((holds_done == 0 && results_taken >= 120) ||
          (holds_done == 1 && results_taken >= 500)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Monitor: check taken result words, predict on taken file bytes.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t typed;
    int      n_queued;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
        $display("pcap_record_deframer_core_test NOT OK");
        $finish;
      end else begin
        if (out_valid && out_ready) begin
          results_taken++;
          if (parsed_words.size() == 0) begin
            $display("%0t: unexpected result word, kind %0d", $time, out_kind);
            fails++;
          end else begin
            want = parsed_words.pop_front();
            check_field("kind", 32'(want.kind), 32'(out_kind));
            check_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
            check_field("frame_end", 32'(want.frame_end), 32'(out_frame_end));
            check_field("seconds", want.seconds, out_seconds);
            check_field("nanoseconds", want.nanoseconds, out_nanoseconds);
            check_field("captured_len", want.captured_len, out_captured_len);
            check_field("original_len", want.original_len, out_original_len);
            check_field("link_type", 32'(want.link_type), 32'(out_link_type));
            check_field("error_code", 32'(want.error_code), 32'(out_error_code));
            check_field("run_last", 32'(want.run_last), 32'(out_run_last));
          end
        end
        if (in_valid && in_ready) begin
          n_queued = parsed_words.size();
          parse_file_byte(in_file_byte, in_end_of_file);
          // hand-written error report for directed rows
          if (capture_bytes[accepted_count].typed_err != ERR_NONE) begin
            typed = '0;
            typed.kind = KIND_ERROR;
            typed.error_code = capture_bytes[accepted_count].typed_err;
            typed.run_last = 1'b1;
            if (parsed_words.size() > n_queued) void'(parsed_words.pop_back());
            parsed_words.insert(parsed_words.size(), typed);
          end
          accepted_count++;
        end
      end
    end
  end

  initial begin : main
    file_plan_t plan;
    int         useful;
    int         counted;
    int         r;
    clear_parser();
    foreach (DIRECTED[i]) add_file(DIRECTED[i], 1'b0, useful);

    // Random files: mostly well-formed, some bad magic, short or cut off.
    counted = capture_bytes.size();
    while (counted < ITEMS_WANTED) begin
      r = $urandom_range(0, 99);
      if (r < 80) plan.magic = good_magics[$urandom_range(0, 3)];
      else if (r < 90) plan.magic = good_magics[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
      else plan.magic = $urandom();
      plan.link_word = $urandom();
      plan.records   = 4'($urandom_range(0, 5));
      plan.caplen    = '0;
      plan.stamp     = '0;
      plan.typed_err = ERR_NONE;
      r = $urandom_range(0, 99);
      if (r < 60) plan.stop_at = '0;
      else if (r < 72) plan.stop_at = 16'($urandom_range(1, GLOBAL_LEN - 1));
      else plan.stop_at = 16'($urandom_range(GLOBAL_LEN, GLOBAL_LEN + 30 * plan.records + 16));
      add_file(plan, 1'b1, useful);
      counted += useful;
    end
    cycle_limit = 10000 + capture_bytes.size() * 250;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count < capture_bytes.size()) @(posedge clk);
    while (parsed_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fails == 0) $display("pcap_record_deframer_core_test OK");
    else $display("pcap_record_deframer_core_test NOT OK");
    $finish;
  end

endmodule

[filelist.f]
rtl/pcapdf_pkg.sv
rtl/pcap_record_deframer_core.sv
test/pcap_record_deframer_core_test.sv
